### rtl/core/hall_mhd_y_flux_assert.svh
// ---------------------------------------------------------------------------
// hall y flux assertion macros
// clocked assertion forms for the rtl checker
// ---------------------------------------------------------------------------
`ifndef HALL_MHD_Y_FLUX_ASSERT_SVH
`define HALL_MHD_Y_FLUX_ASSERT_SVH

// checked out of reset
`define HMF_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("hall y flux assertion failed");

// checked on every edge, reset included
`define HMF_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("hall y flux assertion failed");

`endif

### rtl/core/hmf_pkg.sv
// ---------------------------------------------------------------------------
// hall y flux package
// fixed-point types, saturating arithmetic and pipeline constants
// ---------------------------------------------------------------------------
package hmf_pkg;

   localparam int DIV_STEP_BITS = 4;
   localparam int DIV_ITER      = 32 / DIV_STEP_BITS;
   localparam int DIV_STAGES    = DIV_ITER + 2;
   localparam int ST_DIV        = 4;
   localparam int ST_POST       = ST_DIV + DIV_STAGES;
   localparam int POST_STAGES   = 7;
   localparam int N_STAGES      = ST_POST + POST_STAGES;

   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_GAMMA = 2'd0;
   localparam logic [1:0] REG_HALL  = 2'd1;
   localparam logic [1:0] REG_DI    = 2'd2;
   localparam logic [18:0] GAMMA_RESET = 19'd109227;

   localparam logic signed [31:0] Q_MAX   = 32'sh7fffffff;
   localparam logic signed [31:0] Q_MIN   = 32'sh80000000;
   localparam logic signed [31:0] Q_ONE   = 32'sd65536;
   localparam logic signed [31:0] Q_TENTH = 32'sd6554;

   typedef struct packed {
      logic              sat;
      logic signed [31:0] val;
   } q_type;

   typedef struct packed {
      logic              neg;
      logic              ovf;
      logic [31:0]       den;
      logic [31:0]       rem;
      logic [31:0]       nlo;
      logic [31:0]       quo;
   } div_type;

   function automatic q_type q_clamp(input logic signed [63:0] v);
      q_type r;
      if (v > 64'sd2147483647) begin
         r.sat = 1'b1;
         r.val = Q_MAX;
      end else if (v < -64'sd2147483648) begin
         r.sat = 1'b1;
         r.val = Q_MIN;
      end else begin
         r.sat = 1'b0;
         r.val = v[31:0];
      end
      return r;
   endfunction

   function automatic q_type q_add(input logic signed [31:0] a, input logic signed [31:0] b);
      logic signed [63:0] s;
      s = 64'(a) + 64'(b);
      return q_clamp(s);
   endfunction

   function automatic q_type q_sub(input logic signed [31:0] a, input logic signed [31:0] b);
      logic signed [63:0] s;
      s = 64'(a) - 64'(b);
      return q_clamp(s);
   endfunction

   function automatic q_type q_mul(input logic signed [31:0] a, input logic signed [31:0] b);
      logic signed [63:0] pr;
      pr = a * b;
      return q_clamp(pr >>> 16);
   endfunction

   function automatic logic signed [31:0] q_half(input logic signed [31:0] a);
      return a >>> 1;
   endfunction

endpackage

### rtl/core/hmf_req_if.sv
// ---------------------------------------------------------------------------
// hall y flux request channel
// one cell of conserved quantities and current density
// ---------------------------------------------------------------------------
interface hmf_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] density;
   logic signed [31:0] momentum_x;
   logic signed [31:0] momentum_y;
   logic signed [31:0] momentum_z;
   logic signed [31:0] field_x;
   logic signed [31:0] field_y;
   logic signed [31:0] field_z;
   logic signed [31:0] total_energy;
   logic signed [31:0] current_x;
   logic signed [31:0] current_y;
   logic signed [31:0] current_z;

   modport source (
      output valid, density, momentum_x, momentum_y, momentum_z, field_x, field_y,
             field_z, total_energy, current_x, current_y, current_z,
      input  ready
   );
   modport sink (
      input  valid, density, momentum_x, momentum_y, momentum_z, field_x, field_y,
             field_z, total_energy, current_x, current_y, current_z,
      output ready
   );
endinterface

### rtl/core/hmf_rsp_if.sv
// ---------------------------------------------------------------------------
// hall y flux response channel
// eight y-direction fluxes and a saturation flag
// ---------------------------------------------------------------------------
interface hmf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] flux_density;
   logic signed [31:0] flux_mom_x;
   logic signed [31:0] flux_mom_y;
   logic signed [31:0] flux_mom_z;
   logic signed [31:0] flux_field_x;
   logic signed [31:0] flux_field_y;
   logic signed [31:0] flux_field_z;
   logic signed [31:0] flux_energy;
   logic               saturated;

   modport source (
      output valid, flux_density, flux_mom_x, flux_mom_y, flux_mom_z, flux_field_x,
             flux_field_y, flux_field_z, flux_energy, saturated,
      input  ready
   );
   modport sink (
      input  valid, flux_density, flux_mom_x, flux_mom_y, flux_mom_z, flux_field_x,
             flux_field_y, flux_field_z, flux_energy, saturated,
      output ready
   );
endinterface

### rtl/core/hmf_div.sv
// ---------------------------------------------------------------------------
// hall y flux divider
// pipelined saturating q16.16 quotient, positive divisor, four bits per iteration stage
// ---------------------------------------------------------------------------
module hmf_div
   import hmf_pkg::*;
(
   input  logic                  clock,
   input  logic [DIV_STAGES-1:0] stage_en,
   input  logic signed [31:0]    num,
   input  logic [31:0]           den,
   output q_type                 quo
);

   div_type dst_ff [DIV_ITER+1];
   div_type dst_in [DIV_ITER+1];
   q_type   quo_ff;
   q_type   quo_in;

   always_comb begin : prep
      logic [32:0] m;
      logic [31:0] mag;
      m = num[31] ? (33'd0 - {1'b1, num}) : {1'b0, num};
      mag = m[31:0];
      dst_in[0].neg = num[31];
      dst_in[0].ovf = {16'd0, mag} >= {den, 16'd0};
      dst_in[0].den = den;
      dst_in[0].rem = {16'd0, mag[31:16]};
      dst_in[0].nlo = {mag[15:0], 16'd0};
      dst_in[0].quo = '0;
   end

   for (genvar g = 1; g <= DIV_ITER; g++) begin : g_iter
      always_comb begin : step
         logic [32:0] r2;
         logic [31:0] rem;
         logic [31:0] nlo;
         logic [31:0] q;
         rem = dst_ff[g-1].rem;
         nlo = dst_ff[g-1].nlo;
         q = dst_ff[g-1].quo;
         for (int k = 0; k < DIV_STEP_BITS; k++) begin
            r2 = {rem, nlo[31]};
            nlo = {nlo[30:0], 1'b0};
            if (r2 >= {1'b0, dst_ff[g-1].den}) begin
               rem = 32'(r2 - {1'b0, dst_ff[g-1].den});
               q = {q[30:0], 1'b1};
            end else begin
               rem = r2[31:0];
               q = {q[30:0], 1'b0};
            end
         end
         dst_in[g] = dst_ff[g-1];
         dst_in[g].rem = rem;
         dst_in[g].nlo = nlo;
         dst_in[g].quo = q;
      end
   end

   always_comb begin
      quo_in.sat = 1'b0;
      quo_in.val = dst_ff[DIV_ITER].quo;
      if (dst_ff[DIV_ITER].ovf) begin
         quo_in.sat = 1'b1;
         quo_in.val = dst_ff[DIV_ITER].neg ? Q_MIN : Q_MAX;
      end else if (!dst_ff[DIV_ITER].neg) begin
         if (dst_ff[DIV_ITER].quo[31]) begin
            quo_in.sat = 1'b1;
            quo_in.val = Q_MAX;
         end
      end else if (dst_ff[DIV_ITER].quo > 32'h80000000) begin
         quo_in.sat = 1'b1;
         quo_in.val = Q_MIN;
      end else begin
         quo_in.val = $signed(32'd0 - dst_ff[DIV_ITER].quo);
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= DIV_ITER; s++) begin
         if (stage_en[s]) begin
            dst_ff[s] <= dst_in[s];
         end
      end
      if (stage_en[DIV_STAGES-1]) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

### rtl/core/hall_mhd_y_flux.sv
// ---------------------------------------------------------------------------
// hall y flux
// y-direction fluxes of one cell with optional hall induction terms
// ---------------------------------------------------------------------------
// Accepts one cell per clock unless a stalled response backs the pipe up.
// A ten-stage divider (four quotient bits per iteration stage) forms the
// velocities and the hall terms, with three hall product stages before it
// and seven flux stages after it. A stalled response holds the pipe only
// as far back as the first empty stage. Registers sit at 0x0 (adiabatic
// index), 0x4 (hall enable) and 0x8 (inertial length).
module hall_mhd_y_flux
   import hmf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   hmf_req_if.sink               req,
   hmf_rsp_if.source             rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   typedef struct packed {
      logic signed [31:0] rho;
      logic signed [31:0] mx;
      logic signed [31:0] my;
      logic signed [31:0] mz;
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic signed [31:0] bz;
      logic signed [31:0] en;
      logic signed [31:0] jx;
      logic signed [31:0] jy;
      logic signed [31:0] jz;
      logic               rho_bad;
      logic               hsat;
   } cell_type;

   typedef struct packed {
      logic signed [31:0] my;
      logic signed [31:0] en;
      logic signed [31:0] by;
      logic signed [31:0] vy;
      logic signed [31:0] ex;
      logic signed [31:0] ez;
      logic signed [31:0] mxvx;
      logic signed [31:0] myvy;
      logic signed [31:0] mzvz;
      logic signed [31:0] bxbx;
      logic signed [31:0] byby;
      logic signed [31:0] bzbz;
      logic signed [31:0] mxvy;
      logic signed [31:0] bxby;
      logic signed [31:0] mzvy;
      logic signed [31:0] bybz;
      logic signed [31:0] bxvy;
      logic signed [31:0] byvx;
      logic signed [31:0] bzvy;
      logic signed [31:0] byvz;
      logic signed [31:0] bxvx;
      logic signed [31:0] byvy;
      logic signed [31:0] bzvz;
      logic signed [31:0] kin;
      logic signed [31:0] bsq;
      logic signed [31:0] f1;
      logic signed [31:0] f2;
      logic signed [31:0] f3;
      logic signed [31:0] f4;
      logic signed [31:0] f6;
      logic signed [31:0] f7;
      logic signed [31:0] w;
      logic signed [31:0] t;
      logic signed [31:0] hbsq;
      logic signed [31:0] bw;
      logic signed [31:0] p;
      logic signed [31:0] ps;
      logic signed [31:0] eps;
      logic signed [31:0] epsvy;
      logic               sat;
   } post_type;

   logic [18:0] gamma_ff;
   logic        hall_ff;
   logic [20:0] di_ff;

   logic [N_STAGES-1:0] v_ff;
   logic [N_STAGES-1:0] en;

   cell_type cell_ff [ST_POST];
   cell_type cell_in [ST_POST];
   q_type    hp_ff [4];
   q_type    hp_in [4];
   q_type    hd_ff [2];
   q_type    hd_in [2];
   q_type    hs_ff [2];
   q_type    hs_in [2];
   post_type post_ff [POST_STAGES];
   post_type post_in [POST_STAGES];

   q_type              dq [5];
   logic signed [31:0] gm1;
   logic signed [31:0] di_q;
   logic [31:0]        vel_den;
   logic [31:0]        reff;
   logic               csr_write;

   // configuration
   assign csr_write = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= GAMMA_RESET;
         hall_ff <= 1'b0;
         di_ff <= '0;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_GAMMA: gamma_ff <= pwdata[18:0];
            REG_HALL:  hall_ff <= pwdata[0];
            REG_DI:    di_ff <= pwdata[20:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_GAMMA: prdata = {13'd0, gamma_ff};
         REG_HALL:  prdata = {31'd0, hall_ff};
         REG_DI:    prdata = {11'd0, di_ff};
         default:   prdata = '0;
      endcase
   end

   assign gm1 = $signed({13'd0, gamma_ff}) - Q_ONE;
   assign di_q = $signed({11'd0, di_ff});

   // stage enables
   always_comb begin
      en[N_STAGES-1] = !v_ff[N_STAGES-1] || rsp.ready;
      for (int s = N_STAGES - 2; s >= 0; s--) begin
         en[s] = !v_ff[s] || en[s+1];
      end
   end

   assign req.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req.valid;
         end
         for (int s = 1; s < N_STAGES; s++) begin
            if (en[s]) begin
               v_ff[s] <= v_ff[s-1];
            end
         end
      end
   end

   // capture and hall numerators
   always_comb begin
      cell_in[0].rho = req.density;
      cell_in[0].mx = req.momentum_x;
      cell_in[0].my = req.momentum_y;
      cell_in[0].mz = req.momentum_z;
      cell_in[0].bx = req.field_x;
      cell_in[0].by = req.field_y;
      cell_in[0].bz = req.field_z;
      cell_in[0].en = req.total_energy;
      cell_in[0].jx = req.current_x;
      cell_in[0].jy = req.current_y;
      cell_in[0].jz = req.current_z;
      cell_in[0].rho_bad = req.density <= 32'sd0;
      cell_in[0].hsat = 1'b0;

      hp_in[0] = q_mul(cell_ff[0].jy, cell_ff[0].bz);
      hp_in[1] = q_mul(cell_ff[0].jz, cell_ff[0].by);
      hp_in[2] = q_mul(cell_ff[0].jx, cell_ff[0].by);
      hp_in[3] = q_mul(cell_ff[0].jy, cell_ff[0].bx);
      cell_in[1] = cell_ff[0];
      cell_in[1].hsat = hp_in[0].sat | hp_in[1].sat | hp_in[2].sat | hp_in[3].sat;

      hd_in[0] = q_sub(hp_ff[0].val, hp_ff[1].val);
      hd_in[1] = q_sub(hp_ff[2].val, hp_ff[3].val);
      cell_in[2] = cell_ff[1];
      cell_in[2].hsat = cell_ff[1].hsat | hd_in[0].sat | hd_in[1].sat;

      hs_in[0] = q_mul(di_q, hd_ff[0].val);
      hs_in[1] = q_mul(di_q, hd_ff[1].val);
      cell_in[3] = cell_ff[2];
      cell_in[3].hsat = cell_ff[2].hsat | hs_in[0].sat | hs_in[1].sat;

      for (int s = ST_DIV; s < ST_POST; s++) begin
         cell_in[s] = cell_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < ST_POST; s++) begin
         if (en[s]) begin
            cell_ff[s] <= cell_in[s];
         end
      end
      if (en[1]) begin
         hp_ff <= hp_in;
      end
      if (en[2]) begin
         hd_ff <= hd_in;
      end
      if (en[3]) begin
         hs_ff <= hs_in;
      end
   end

   // quotients
   assign vel_den = cell_ff[ST_DIV-1].rho_bad ? 32'd1 : cell_ff[ST_DIV-1].rho;
   assign reff = (cell_ff[ST_DIV-1].rho > Q_TENTH) ? cell_ff[ST_DIV-1].rho : Q_TENTH;

   hmf_div u_div_vx (
      .clock(clock), .stage_en(en[ST_DIV +: DIV_STAGES]),
      .num(cell_ff[ST_DIV-1].mx), .den(vel_den), .quo(dq[0])
   );
   hmf_div u_div_vy (
      .clock(clock), .stage_en(en[ST_DIV +: DIV_STAGES]),
      .num(cell_ff[ST_DIV-1].my), .den(vel_den), .quo(dq[1])
   );
   hmf_div u_div_vz (
      .clock(clock), .stage_en(en[ST_DIV +: DIV_STAGES]),
      .num(cell_ff[ST_DIV-1].mz), .den(vel_den), .quo(dq[2])
   );
   hmf_div u_div_ex (
      .clock(clock), .stage_en(en[ST_DIV +: DIV_STAGES]),
      .num(hs_ff[0].val), .den(reff), .quo(dq[3])
   );
   hmf_div u_div_ez (
      .clock(clock), .stage_en(en[ST_DIV +: DIV_STAGES]),
      .num(hs_ff[1].val), .den(reff), .quo(dq[4])
   );

   // products of velocities and fields
   always_comb begin : post_products
      cell_type           c;
      post_type           p;
      q_type              m;
      logic               sat;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
      c = cell_ff[ST_POST-1];
      p = '0;
      sat = hall_ff & (c.hsat | dq[3].sat | dq[4].sat);
      if (c.rho_bad) begin
         sat = 1'b1;
         vx = c.mx[31] ? Q_MIN : Q_MAX;
         vy = c.my[31] ? Q_MIN : Q_MAX;
         vz = c.mz[31] ? Q_MIN : Q_MAX;
      end else begin
         sat = sat | dq[0].sat | dq[1].sat | dq[2].sat;
         vx = dq[0].val;
         vy = dq[1].val;
         vz = dq[2].val;
      end
      p.my = c.my;
      p.en = c.en;
      p.by = c.by;
      p.vy = vy;
      p.ex = hall_ff ? dq[3].val : 32'sd0;
      p.ez = hall_ff ? dq[4].val : 32'sd0;
      m = q_mul(c.mx, vx); p.mxvx = m.val; sat |= m.sat;
      m = q_mul(c.my, vy); p.myvy = m.val; sat |= m.sat;
      m = q_mul(c.mz, vz); p.mzvz = m.val; sat |= m.sat;
      m = q_mul(c.bx, c.bx); p.bxbx = m.val; sat |= m.sat;
      m = q_mul(c.by, c.by); p.byby = m.val; sat |= m.sat;
      m = q_mul(c.bz, c.bz); p.bzbz = m.val; sat |= m.sat;
      m = q_mul(c.mx, vy); p.mxvy = m.val; sat |= m.sat;
      m = q_mul(c.bx, c.by); p.bxby = m.val; sat |= m.sat;
      m = q_mul(c.mz, vy); p.mzvy = m.val; sat |= m.sat;
      m = q_mul(c.by, c.bz); p.bybz = m.val; sat |= m.sat;
      m = q_mul(c.bx, vy); p.bxvy = m.val; sat |= m.sat;
      m = q_mul(c.by, vx); p.byvx = m.val; sat |= m.sat;
      m = q_mul(c.bz, vy); p.bzvy = m.val; sat |= m.sat;
      m = q_mul(c.by, vz); p.byvz = m.val; sat |= m.sat;
      m = q_mul(c.bx, vx); p.bxvx = m.val; sat |= m.sat;
      m = q_mul(c.by, vy); p.byvy = m.val; sat |= m.sat;
      m = q_mul(c.bz, vz); p.bzvz = m.val; sat |= m.sat;
      p.sat = sat;
      post_in[0] = p;
   end

   // sums, pressure and fluxes
   always_comb begin : post_stages
      post_type p;
      q_type    m;
      q_type    n;

      // kinetic and magnetic sums, flux differences
      p = post_ff[0];
      m = q_add(p.mxvx, p.myvy); p.sat |= m.sat;
      n = q_add(m.val, p.mzvz); p.kin = n.val; p.sat |= n.sat;
      m = q_add(p.bxbx, p.byby); p.sat |= m.sat;
      n = q_add(m.val, p.bzbz); p.bsq = n.val; p.sat |= n.sat;
      m = q_add(p.bxvx, p.byvy); p.sat |= m.sat;
      n = q_add(m.val, p.bzvz); p.w = n.val; p.sat |= n.sat;
      m = q_sub(p.mxvy, p.bxby); p.f1 = m.val; p.sat |= m.sat;
      m = q_sub(p.mzvy, p.bybz); p.f3 = m.val; p.sat |= m.sat;
      m = q_sub(p.bxvy, p.byvx); p.f4 = m.val; p.sat |= m.sat;
      m = q_sub(p.bzvy, p.byvz); p.f6 = m.val; p.sat |= m.sat;
      post_in[1] = p;

      // internal energy, magnetic work and hall terms
      p = post_ff[1];
      p.hbsq = q_half(p.bsq);
      m = q_sub(p.en, q_half(p.kin)); p.sat |= m.sat;
      n = q_sub(m.val, p.hbsq); p.t = n.val; p.sat |= n.sat;
      m = q_mul(p.by, p.w); p.bw = m.val; p.sat |= m.sat;
      m = q_add(p.f4, p.ez); p.f4 = m.val; p.sat |= m.sat;
      m = q_sub(p.f6, p.ex); p.f6 = m.val; p.sat |= m.sat;
      post_in[2] = p;

      // gas pressure
      p = post_ff[2];
      m = q_mul(gm1, p.t); p.p = m.val; p.sat |= m.sat;
      post_in[3] = p;

      // total pressure
      p = post_ff[3];
      m = q_add(p.p, p.hbsq); p.ps = m.val; p.sat |= m.sat;
      post_in[4] = p;

      // y momentum flux and energy plus pressure
      p = post_ff[4];
      m = q_add(p.myvy, p.ps); p.sat |= m.sat;
      n = q_sub(m.val, p.byby); p.f2 = n.val; p.sat |= n.sat;
      m = q_add(p.en, p.ps); p.eps = m.val; p.sat |= m.sat;
      post_in[5] = p;

      // energy flux
      p = post_ff[5];
      m = q_mul(p.eps, p.vy); p.epsvy = m.val; p.sat |= m.sat;
      n = q_sub(p.epsvy, p.bw); p.f7 = n.val; p.sat |= n.sat;
      post_in[6] = p;
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < POST_STAGES; s++) begin
         if (en[ST_POST+s]) begin
            post_ff[s] <= post_in[s];
         end
      end
   end

   // response
   assign rsp.valid        = v_ff[N_STAGES-1];
   assign rsp.flux_density = post_ff[POST_STAGES-1].my;
   assign rsp.flux_mom_x   = post_ff[POST_STAGES-1].f1;
   assign rsp.flux_mom_y   = post_ff[POST_STAGES-1].f2;
   assign rsp.flux_mom_z   = post_ff[POST_STAGES-1].f3;
   assign rsp.flux_field_x = post_ff[POST_STAGES-1].f4;
   assign rsp.flux_field_y = '0;
   assign rsp.flux_field_z = post_ff[POST_STAGES-1].f6;
   assign rsp.flux_energy  = post_ff[POST_STAGES-1].f7;
   assign rsp.saturated    = post_ff[POST_STAGES-1].sat;

endmodule

### rtl/core/hmf_chk.sv
// ---------------------------------------------------------------------------
// hall y flux checker
// port-level properties of the flux pipeline, bound to the top level
// ---------------------------------------------------------------------------
`include "hall_mhd_y_flux_assert.svh"

module hmf_chk (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_flux_field_y,
   input logic signed [31:0] rsp_flux_energy,
   input logic               pready
);

   `HMF_ASSERT(a_field_y_zero, rsp_valid |-> rsp_flux_field_y == 32'sd0)
   `HMF_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_flux_energy))
   `HMF_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid)
   `HMF_ASSERT_ALWAYS(a_pready_high, pready)

endmodule

bind hall_mhd_y_flux hmf_chk u_hmf_chk (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_flux_field_y(rsp.flux_field_y),
   .rsp_flux_energy(rsp.flux_energy),
   .pready(pready)
);

### bench/hall_mhd_y_flux_checker.sv
// ---------------------------------------------------------------------------
// hall y flux checker
// watches both channels and the register port, predicts the fluxes of every
// accepted request and compares each response with the oldest prediction
// ---------------------------------------------------------------------------
module hall_mhd_y_flux_checker
   import hmf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   hmf_req_if                    req,
   hmf_rsp_if                    rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   input  logic                  pready,
   output int                    errors,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] f[8];
      logic               sat;
   } fluxes_t;

   fluxes_t     flux_queue[$];
   logic [18:0] gamma_q;
   logic        hall_on;
   logic [20:0] di_q;

   function automatic longint clip(input longint v, inout bit s);
      if (v > 64'sd2147483647) begin
         s = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         s = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint fmul(input longint a, input longint b, inout bit s);
      return clip((a * b) >>> 16, s);
   endfunction

   function automatic longint fdiv(input longint a, input longint d, inout bit s);
      return clip((a * 65536) / d, s);
   endfunction

   function automatic longint speed(input longint num, input longint rho, inout bit s);
      if (rho <= 0) begin
         s = 1;
         return (num >= 0) ? 64'sd2147483647 : -64'sd2147483648;
      end
      return fdiv(num, rho, s);
   endfunction

   function automatic fluxes_t cell_fluxes(input longint c[11]);
      fluxes_t r;
      bit      s;
      longint  rho, mx, my, mz, bx, by, bz, en, jx, jy, jz;
      longint  vx, vy, vz, kin, bsq, gm1, p, ps, ex, ez, reff;
      s = 0;
      rho = c[0]; mx = c[1]; my = c[2]; mz = c[3];
      bx = c[4]; by = c[5]; bz = c[6]; en = c[7];
      jx = c[8]; jy = c[9]; jz = c[10];
      ex = 0;
      ez = 0;
      vx = speed(mx, rho, s);
      vy = speed(my, rho, s);
      vz = speed(mz, rho, s);
      kin = clip(clip(fmul(mx, vx, s) + fmul(my, vy, s), s) + fmul(mz, vz, s), s);
      bsq = clip(clip(fmul(bx, bx, s) + fmul(by, by, s), s) + fmul(bz, bz, s), s);
      gm1 = longint'(gamma_q) - 65536;
      p = fmul(gm1, clip(clip(en - (kin >>> 1), s) - (bsq >>> 1), s), s);
      ps = clip(p + (bsq >>> 1), s);
      if (hall_on) begin
         reff = (rho > 6554) ? rho : 6554;
         ex = fdiv(fmul(longint'(di_q),
                        clip(fmul(jy, bz, s) - fmul(jz, by, s), s), s), reff, s);
         ez = fdiv(fmul(longint'(di_q),
                        clip(fmul(jx, by, s) - fmul(jy, bx, s), s), s), reff, s);
      end
      r.f[0] = my;
      r.f[1] = clip(fmul(mx, vy, s) - fmul(bx, by, s), s);
      r.f[2] = clip(clip(fmul(my, vy, s) + ps, s) - fmul(by, by, s), s);
      r.f[3] = clip(fmul(mz, vy, s) - fmul(by, bz, s), s);
      r.f[4] = clip(clip(fmul(bx, vy, s) - fmul(by, vx, s), s) + ez, s);
      r.f[5] = 0;
      r.f[6] = clip(clip(fmul(bz, vy, s) - fmul(by, vz, s), s) - ex, s);
      r.f[7] = clip(fmul(clip(en + ps, s), vy, s)
                    - fmul(by, clip(clip(fmul(bx, vx, s) + fmul(by, vy, s), s)
                                    + fmul(bz, vz, s), s), s), s);
      r.sat = s;
      return r;
   endfunction

   assign pending = flux_queue.size();

   always @(posedge clock) begin
      longint  c[11];
      fluxes_t e;
      logic signed [31:0] got[8];
      bit      bad;
      if (reset) begin
         gamma_q <= GAMMA_RESET;
         hall_on <= 1'b0;
         di_q    <= '0;
         errors  <= 0;
         flux_queue.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == CSR_ADDR_W'(REG_GAMMA) * 4) gamma_q <= pwdata[18:0];
            if (paddr == CSR_ADDR_W'(REG_HALL) * 4)  hall_on <= pwdata[0];
            if (paddr == CSR_ADDR_W'(REG_DI) * 4)    di_q    <= pwdata[20:0];
         end
         if (req.valid && req.ready) begin
            c = '{req.density, req.momentum_x, req.momentum_y, req.momentum_z,
                  req.field_x, req.field_y, req.field_z, req.total_energy,
                  req.current_x, req.current_y, req.current_z};
            flux_queue.push_back(cell_fluxes(c));
         end
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.flux_density, rsp.flux_mom_x, rsp.flux_mom_y, rsp.flux_mom_z,
                    rsp.flux_field_x, rsp.flux_field_y, rsp.flux_field_z,
                    rsp.flux_energy};
            if (flux_queue.size() == 0) begin
               if (errors < 10) $display("unexpected response at %0t", $realtime);
               errors <= errors + 1;
            end else begin
               e = flux_queue.pop_front();
               bad = (rsp.saturated !== e.sat);
               for (int k = 0; k < 8; k++) if (got[k] !== e.f[k]) bad = 1;
               if (bad) begin
                  if (errors < 10) begin
                     $display("mismatch at %0t: sat exp %0b got %0b", $realtime,
                              e.sat, rsp.saturated);
                     for (int k = 0; k < 8; k++)
                        $display("  flux %0d exp %0d got %0d", k, e.f[k], got[k]);
                  end
                  errors <= errors + 1;
               end
            end
         end
      end
   end
endmodule

### bench/hall_mhd_y_flux_test.sv
// ---------------------------------------------------------------------------
// hall y flux testbench
// drives directed and random cells under several register settings with
// random gaps on both channels, and reports the checker's verdict
// ---------------------------------------------------------------------------
module hall_mhd_y_flux_test
   import hmf_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 5000;

   logic                  clock;
   logic                  reset;
   logic                  psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;
   int                    errors, pending, idle_cycles, responses;

   hmf_req_if req ();
   hmf_rsp_if rsp ();

   hall_mhd_y_flux uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   hall_mhd_y_flux_checker chk (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("hall_mhd_y_flux verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver, with one long hold-off to back the pipe up
   initial begin
      int n;
      rsp.ready = 0;
      responses = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (responses == 100) begin
            rsp.ready <= 0;
            repeat (300) @(posedge clock);
         end else begin
            n = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) n = 0;
            if (n > 0) begin
               rsp.ready <= 0;
               repeat (n) @(posedge clock);
            end
         end
         rsp.ready <= 1;
         do @(posedge clock); while (!(rsp.valid && rsp.ready));
         responses++;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1;
      pwrite  <= 1;
      penable <= 0;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel    <= 0;
      penable <= 0;
      pwrite  <= 0;
   endtask

   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic send_cell(input logic signed [31:0] c[11]);
      int gap;
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req.valid        <= 1;
      req.density      <= c[0];
      req.momentum_x   <= c[1];
      req.momentum_y   <= c[2];
      req.momentum_z   <= c[3];
      req.field_x      <= c[4];
      req.field_y      <= c[5];
      req.field_z      <= c[6];
      req.total_energy <= c[7];
      req.current_x    <= c[8];
      req.current_y    <= c[9];
      req.current_z    <= c[10];
      do @(posedge clock); while (!req.ready);
   endtask

   function automatic logic signed [31:0] near(input int span);
      return $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   task automatic send_random(input int count);
      logic signed [31:0] c[11];
      repeat (count) begin
         if ($urandom_range(0, 9) < 2) begin
            foreach (c[k]) c[k] = $urandom;
         end else begin
            case ($urandom_range(0, 3))
               0: c[0] = $urandom_range(1, 6554);
               1: c[0] = $urandom_range(6554, 65536);
               default: c[0] = $urandom_range(65536, 16 << 16);
            endcase
            if ($urandom_range(0, 15) == 0) c[0] = -$signed($urandom_range(0, 65536));
            for (int k = 1; k < 11; k++) c[k] = near(8 << 16);
            c[7] = $urandom_range(0, 64 << 16);
         end
         send_cell(c);
      end
   endtask

   initial begin
      logic signed [31:0] d[11];
      reset = 1;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      req.valid = 0;
      req.density = 0; req.momentum_x = 0; req.momentum_y = 0; req.momentum_z = 0;
      req.field_x = 0; req.field_y = 0; req.field_z = 0; req.total_energy = 0;
      req.current_x = 0; req.current_y = 0; req.current_z = 0;
      repeat (7) @(posedge clock);
      reset <= 0;

      send_random(300);
      req.valid <= 0;
      drain();

      csr_write(REG_GAMMA, 32'd65536);
      csr_write(REG_HALL, 32'hffff_ffff);
      csr_write(REG_DI, 32'd1048576);
      csr_write(2'd3, 32'h1234_5678);

      // directed cells: zeros, extremes, nonpositive and tiny densities
      d = '{default: 0};
      send_cell(d);
      d = '{default: 32'sh7fffffff};
      send_cell(d);
      d = '{default: 32'sh80000000};
      send_cell(d);
      d = '{0, 65536, -65536, 65536, 65536, 65536, 65536, 65536, 65536, 65536, 65536};
      send_cell(d);
      d = '{-65536, -65536, 65536, 0, 65536, 65536, 65536, 65536, 65536, 65536, 65536};
      send_cell(d);
      d = '{32'sh80000000, 5, -5, 0, 1, 2, 3, 4, 5, 6, 7};
      send_cell(d);
      d = '{1, 65536, 65536, -65536, 65536, -65536, 65536, 0, 65536, 65536, 65536};
      send_cell(d);
      d = '{6554, 655, -655, 655, 65536, 65536, -65536, 65536, 65536, -65536, 65536};
      send_cell(d);
      d = '{6553, 655, 655, 655, 65536, 65536, 65536, 65536, 65536, 65536, 65536};
      send_cell(d);
      d = '{6555, 655, 655, 655, 65536, 65536, 65536, 65536, 65536, 65536, 65536};
      send_cell(d);
      d = '{65536, 131072, 196608, 262144, 65536, 131072, 196608, 655360, 0, 0, 0};
      send_cell(d);
      d = '{65536, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0,
            32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
      send_cell(d);
      d = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1, -1, 1,
            32'sh80000000, -1, 1, -1};
      send_cell(d);
      d = '{131072, 65536, 65536, 65536, 0, 65536, 0, 32'sh80000000, 0, 0, 0};
      send_cell(d);
      d = '{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
            32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
            32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555};
      send_cell(d);
      send_random(360);
      req.valid <= 0;
      drain();

      csr_write(REG_GAMMA, 32'hfff4_0000);
      csr_write(REG_DI, 32'd0);
      send_random(380);
      req.valid <= 0;
      drain();

      csr_write(REG_GAMMA, 32'd98304);
      csr_write(REG_DI, 32'hffe0_0000 | 32'd65536);
      send_random(380);
      req.valid <= 0;
      drain();

      csr_write(REG_HALL, 32'd0);
      csr_write(REG_GAMMA, 32'd109227);
      csr_write(REG_DI, 32'd1048576);
      send_random(380);
      req.valid <= 0;
      drain();

      if (errors == 0 && pending == 0) begin
         $display("hall_mhd_y_flux verification clean");
      end else begin
         $display("hall_mhd_y_flux verification failed");
      end
      $finish;
   end
endmodule
